@@ rtl/can_tx_queue_with_supersede_core_defines.svh @@
// Assertion macros used by the transmit queue datapath.
`ifndef CAN_TX_QUEUE_WITH_SUPERSEDE_CORE_DEFINES_SVH
`define CAN_TX_QUEUE_WITH_SUPERSEDE_CORE_DEFINES_SVH

// Checked only while out of reset; expects clk and arst_n in scope.
`define CTQ_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CTQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ctq_pkg.sv @@
// Types and constants shared by the CAN transmit queue modules.
package ctq_pkg;

	localparam logic [3:0] MAX_BYTES = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MARK,
		ST_PUSH,
		ST_POP_RD,
		ST_POP_CHK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RES_ACK,
		RES_BUSY,
		RES_DIRECT,
		RES_POP
	} res_sel_t;

	typedef struct packed {
		logic        req_type;
		logic        mailbox_free;
		logic [10:0] frame_id;
		logic [3:0]  frame_length;
		logic        remote_request;
		logic        keep_all;
		logic [63:0] frame_data;
	} frame_req_t;

	typedef struct packed {
		logic        status;
		logic        tx_valid;
		logic [10:0] tx_id;
		logic [3:0]  tx_length;
		logic        tx_remote;
		logic [63:0] tx_data;
	} frame_res_t;

	typedef struct packed {
		logic [10:0] id;
		logic [3:0]  len;
		logic        remote;
		logic [63:0] data;
	} entry_t;

	typedef struct packed {
		logic     capture;
		logic     scan_load;
		logic     scan_issue;
		logic     push;
		logic     pop_rd;
		logic     pop_adv;
		logic     pend_load;
		res_sel_t pend_sel;
		logic     out_load;
	} ctq_cmd_t;

	typedef struct packed {
		logic req_type;
		logic mailbox_free;
		logic keep_all;
		logic full;
		logic empty;
		logic scan_end;
		logic stale;
		logic out_free;
	} ctq_sts_t;

endpackage

@@ rtl/ctq_req_if.sv @@
// Request channel: send requests and mailbox-complete events.
interface ctq_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic        mailbox_free;
	logic [10:0] frame_id;
	logic [3:0]  frame_length;
	logic        remote_request;
	logic        keep_all;
	logic [63:0] frame_data;

	modport source (
		output valid, req_type, mailbox_free, frame_id, frame_length,
			remote_request, keep_all, frame_data,
		input ready
	);
	modport sink (
		input valid, req_type, mailbox_free, frame_id, frame_length,
			remote_request, keep_all, frame_data,
		output ready
	);
endinterface

@@ rtl/ctq_res_if.sv @@
// Result channel: status and the frame handed to the transmitter.
interface ctq_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        tx_valid;
	logic [10:0] tx_id;
	logic [3:0]  tx_length;
	logic        tx_remote;
	logic [63:0] tx_data;

	modport source (
		output valid, status, tx_valid, tx_id, tx_length, tx_remote, tx_data,
		input ready
	);
	modport sink (
		input valid, status, tx_valid, tx_id, tx_length, tx_remote, tx_data,
		output ready
	);
endinterface

@@ rtl/ctq_ctrl.sv @@
// Sequencer for the transmit queue: decides, scans, pushes, pops.
module ctq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ctq_pkg::ctq_sts_t sts,
	output ctq_pkg::ctq_cmd_t cmd
);

	ctq_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ctq_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = ctq_pkg::ST_CHECK;
			end
			ctq_pkg::ST_CHECK: begin
				if (sts.req_type) state_nxt = ctq_pkg::ST_POP_RD;
				else if (sts.mailbox_free || sts.full) state_nxt = ctq_pkg::ST_DONE;
				else if (sts.keep_all) state_nxt = ctq_pkg::ST_PUSH;
				else state_nxt = ctq_pkg::ST_MARK;
			end
			ctq_pkg::ST_MARK: begin
				if (sts.scan_end) state_nxt = ctq_pkg::ST_PUSH;
			end
			ctq_pkg::ST_PUSH: begin
				state_nxt = ctq_pkg::ST_DONE;
			end
			ctq_pkg::ST_POP_RD: begin
				if (sts.empty) state_nxt = ctq_pkg::ST_DONE;
				else state_nxt = ctq_pkg::ST_POP_CHK;
			end
			ctq_pkg::ST_POP_CHK: begin
				if (sts.stale) state_nxt = ctq_pkg::ST_POP_RD;
				else state_nxt = ctq_pkg::ST_DONE;
			end
			ctq_pkg::ST_DONE: begin
				if (sts.out_free) state_nxt = ctq_pkg::ST_IDLE;
			end
			default: state_nxt = ctq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		cmd.pend_sel = ctq_pkg::RES_ACK;
		unique case (state_q)
			ctq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ctq_pkg::ST_CHECK: begin
				if (!sts.req_type) begin
					if (sts.mailbox_free) begin
						cmd.pend_load = 1'b1;
						cmd.pend_sel  = ctq_pkg::RES_DIRECT;
					end else if (sts.full) begin
						cmd.pend_load = 1'b1;
						cmd.pend_sel  = ctq_pkg::RES_BUSY;
					end else if (!sts.keep_all) begin
						cmd.scan_load = 1'b1;
					end
				end
			end
			ctq_pkg::ST_MARK: begin
				cmd.scan_issue = !sts.scan_end;
			end
			ctq_pkg::ST_PUSH: begin
				cmd.push      = 1'b1;
				cmd.pend_load = 1'b1;
				cmd.pend_sel  = ctq_pkg::RES_ACK;
			end
			ctq_pkg::ST_POP_RD: begin
				if (sts.empty) begin
					cmd.pend_load = 1'b1;
					cmd.pend_sel  = ctq_pkg::RES_ACK;
				end else begin
					cmd.pop_rd = 1'b1;
				end
			end
			ctq_pkg::ST_POP_CHK: begin
				cmd.pop_adv = 1'b1;
				if (!sts.stale) begin
					cmd.pend_load = 1'b1;
					cmd.pend_sel  = ctq_pkg::RES_POP;
				end
			end
			ctq_pkg::ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/ctq_dpath.sv @@
// Queue storage, pointers, stale scan and result registers.
`include "can_tx_queue_with_supersede_core_defines.svh"

module ctq_dpath #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctq_pkg::ctq_cmd_t   cmd,
	output ctq_pkg::ctq_sts_t   sts,
	input  ctq_pkg::frame_req_t in_frame,
	input  logic                out_ready,
	output logic                out_valid,
	output ctq_pkg::frame_res_t out_frame
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [3:0] clamp_len(input logic [3:0] len);
		clamp_len = (len > ctq_pkg::MAX_BYTES) ? ctq_pkg::MAX_BYTES : len;
	endfunction

	function automatic logic [63:0] keep_bytes(input logic [63:0] data,
		input logic [3:0] len);
		logic [63:0] res;
		res = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < len) res[8*i +: 8] = data[8*i +: 8];
		end
		keep_bytes = res;
	endfunction

	// captured request
	logic        type_q, free_q, keep_q, remote_q;
	logic [10:0] id_q;
	logic [3:0]  len_q;
	logic [63:0] data_q;

	logic [PTR_W-1:0] wp_q, rp_q, scan_q, scan_s1;
	logic             scan_vld_s1;

	ctq_pkg::entry_t ent_mem [QUEUE_DEPTH];
	logic            stale_mem [QUEUE_DEPTH];
	ctq_pkg::entry_t ent_rd_q;
	logic            stale_rd_q;

	ctq_pkg::frame_res_t pend_q, pend_nxt;
	logic                out_valid_q;
	ctq_pkg::frame_res_t out_q;

	logic             mark_hit;
	logic [PTR_W-1:0] rd_addr;
	logic [3:0]       cap_len;

	assign cap_len  = clamp_len(in_frame.frame_length);
	assign mark_hit = scan_vld_s1 && (ent_rd_q.id == id_q);
	assign rd_addr  = cmd.pop_rd ? rp_q : scan_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q   <= in_frame.req_type;
			free_q   <= in_frame.mailbox_free;
			keep_q   <= in_frame.keep_all;
			remote_q <= in_frame.remote_request;
			id_q     <= in_frame.frame_id;
			len_q    <= cap_len;
			data_q   <= keep_bytes(in_frame.frame_data, cap_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			scan_q      <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			if (cmd.push) wp_q <= next_slot(wp_q);
			if (cmd.pop_adv) rp_q <= next_slot(rp_q);
			if (cmd.scan_load) scan_q <= rp_q;
			else if (cmd.scan_issue) scan_q <= next_slot(scan_q);
			scan_vld_s1 <= cmd.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) scan_s1 <= scan_q;
	end

	// entry store: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.push) ent_mem[wp_q] <= '{id: id_q, len: len_q, remote: remote_q, data: data_q};
		if (cmd.pop_rd || cmd.scan_issue) ent_rd_q <= ent_mem[rd_addr];
	end

	// stale flags: cleared on push, set when a scanned entry read back matches the id
	always_ff @(posedge clk) begin
		if (cmd.push) stale_mem[wp_q] <= 1'b0;
		else if (mark_hit) stale_mem[scan_s1] <= 1'b1;
		if (cmd.pop_rd) stale_rd_q <= stale_mem[rp_q];
	end

	always_comb begin
		pend_nxt = '0;
		case (cmd.pend_sel)
			ctq_pkg::RES_BUSY: pend_nxt.status = 1'b1;
			ctq_pkg::RES_DIRECT: begin
				pend_nxt.tx_valid  = 1'b1;
				pend_nxt.tx_id     = id_q;
				pend_nxt.tx_length = len_q;
				pend_nxt.tx_remote = remote_q;
				pend_nxt.tx_data   = data_q;
			end
			ctq_pkg::RES_POP: begin
				pend_nxt.tx_valid  = 1'b1;
				pend_nxt.tx_id     = ent_rd_q.id;
				pend_nxt.tx_length = ent_rd_q.len;
				pend_nxt.tx_remote = ent_rd_q.remote;
				pend_nxt.tx_data   = ent_rd_q.data;
			end
			default: pend_nxt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_load) pend_q <= pend_nxt;
		if (cmd.out_load) out_q <= pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_frame = out_q;

	always_comb begin
		sts.req_type     = type_q;
		sts.mailbox_free = free_q;
		sts.keep_all     = keep_q;
		sts.full         = (next_slot(wp_q) == rp_q);
		sts.empty        = (rp_q == wp_q);
		sts.scan_end     = (scan_q == wp_q);
		sts.stale        = stale_rd_q;
		sts.out_free     = !out_valid_q || out_ready;
	end

	`CTQ_ASSERT_RST(a_push_not_full, cmd.push |-> (next_slot(wp_q) != rp_q), "push into full queue")
	`CTQ_ASSERT_RST(a_pop_not_empty, cmd.pop_adv |-> (rp_q != wp_q), "read pointer passed write pointer")
	`CTQ_ASSERT_RST(a_no_stale_clash, scan_vld_s1 |-> !cmd.push, "stale mark collides with push")
	`CTQ_ASSERT_ALWAYS(a_no_overwrite, cmd.out_load |-> (!out_valid_q || out_ready), "result word overwritten")

endmodule

@@ rtl/can_tx_queue_with_supersede_core.sv @@
// Top level of the CAN transmit queue with same-identifier supersede.
// Every request word gives exactly one result word. A send with a free
// mailbox, or a send refused as busy, goes straight to a result; a queued
// send with keep_all is pushed, and a superseding send first compares the
// frames queued, one entry compared per cycle, and is then pushed. A
// mailbox-complete event acknowledges an empty queue and otherwise hands
// over a frame, after dropping every stale frame from the head. The
// pace is set by the single read port of the entry memory and the sequencer
// that shares it. A new request is taken once the previous one has been
// handed to the output register, while that result may still wait to be
// taken. No clearing pass follows reset; the queue holds QUEUE_DEPTH - 1 frames.
module can_tx_queue_with_supersede_core #(
	parameter int QUEUE_DEPTH = 8
) (
	input logic       clk,
	input logic       arst_n,
	ctq_req_if.sink   req,
	ctq_res_if.source res
);

	ctq_pkg::ctq_cmd_t   cmd;
	ctq_pkg::ctq_sts_t   sts;
	ctq_pkg::frame_req_t in_frame;
	ctq_pkg::frame_res_t out_frame;
	logic                out_valid;

	always_comb begin
		in_frame.req_type       = req.req_type;
		in_frame.mailbox_free   = req.mailbox_free;
		in_frame.frame_id       = req.frame_id;
		in_frame.frame_length   = req.frame_length;
		in_frame.remote_request = req.remote_request;
		in_frame.keep_all       = req.keep_all;
		in_frame.frame_data     = req.frame_data;
	end

	ctq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ctq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_frame  (in_frame),
		.out_ready (res.ready),
		.out_valid (out_valid),
		.out_frame (out_frame)
	);

	assign res.valid     = out_valid;
	assign res.status    = out_frame.status;
	assign res.tx_valid  = out_frame.tx_valid;
	assign res.tx_id     = out_frame.tx_id;
	assign res.tx_length = out_frame.tx_length;
	assign res.tx_remote = out_frame.tx_remote;
	assign res.tx_data   = out_frame.tx_data;

endmodule
